// ===== src/bitmap_glyph_renderer_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BITMAP_GLYPH_RENDERER_ASSERT_SVH
`define BITMAP_GLYPH_RENDERER_ASSERT_SVH

// Clocked check, masked while reset is held.
`define GBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define GBR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/gbr_pkg.sv =====
`timescale 1ns / 1ps
package gbr_pkg;

  // Font geometry and storage sizes
  localparam int MAX_GLYPH_WIDTH  = 8;
  localparam int MAX_GLYPH_HEIGHT = 8;
  localparam int GLYPH_COUNT      = 256;
  localparam int BIT_STORE_BYTES  = 2048;
  localparam int COORD_BITS       = 12;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int TADDR_W = 11;
  localparam int TVAL_W  = 11;
  localparam int CODE_W  = 8;
  localparam int COLOR_W = 16;
  localparam int ADV_W   = 4;
  localparam int HGT_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int BITC_W  = 3;
  localparam int OFFS_W  = 11;

  // Derived widths
  localparam int GIDX_W  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int BYTE_AW = $clog2(BIT_STORE_BYTES);
  localparam int COL_W   = (MAX_GLYPH_WIDTH > 1) ? $clog2(MAX_GLYPH_WIDTH) : 1;
  localparam int ROW_W   = (MAX_GLYPH_HEIGHT > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_BASE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 1'd1;
  localparam logic [CODE_W-1:0]    CHAR_BASE_RST    = 8'd32;
  localparam logic [HGT_W-1:0]     GLYPH_HEIGHT_RST = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW   = 2'd0,
    OP_WIDTH  = 2'd1,
    OP_OFFSET = 2'd2,
    OP_BYTE   = 2'd3
  } op_t;

  // Table write request
  typedef struct packed {
    logic               en;
    op_t                op;
    logic [TADDR_W-1:0] addr;
    logic [TVAL_W-1:0]  value;
  } tbl_wr_t;

  // Table read requests
  typedef struct packed {
    logic               idx_re;
    logic [GIDX_W-1:0]  idx;
    logic               byte_re;
    logic [BYTE_AW-1:0] byte_addr;
  } tbl_rd_t;

  // Registered table read data
  typedef struct packed {
    logic [ADV_W-1:0]  width;
    logic [OFFS_W-1:0] offset;
    logic [BYTE_W-1:0] glyph;
  } tbl_data_t;

  // Draw request handed to the walker
  typedef struct packed {
    logic                  start;
    logic [GIDX_W-1:0]     idx;
    logic                  idx_ok;
    logic [HGT_W-1:0]      height;
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
    logic [COLOR_W-1:0]    fg;
    logic [COLOR_W-1:0]    bg;
  } draw_t;

  // One result item
  typedef struct packed {
    logic                  pixel_valid;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_W-1:0]    pixel_color;
    logic [ADV_W-1:0]      advance;
    logic                  last;
  } res_t;

  // Next byte address, wrapping at the end of the bit store
  function automatic logic [BYTE_AW-1:0] byte_inc(input logic [BYTE_AW-1:0] a);
    logic [BYTE_AW-1:0] r;
    if (32'(a) == BIT_STORE_BYTES - 1) begin
      r = '0;
    end else begin
      r = a + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== src/gbr_if.sv =====
`timescale 1ns / 1ps
interface gbr_in_if;
  import gbr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [TADDR_W-1:0]    table_addr;
  logic [TVAL_W-1:0]     table_value;
  logic [CODE_W-1:0]     char_code;
  logic [COORD_BITS-1:0] origin_x;
  logic [COORD_BITS-1:0] origin_y;
  logic [COLOR_W-1:0]    fg_color;
  logic [COLOR_W-1:0]    bg_color;

  modport source (output valid, op, table_addr, table_value, char_code, origin_x,
                  origin_y, fg_color, bg_color, input ready);
  modport sink (input valid, op, table_addr, table_value, char_code, origin_x,
                origin_y, fg_color, bg_color, output ready);
endinterface

interface gbr_out_if;
  import gbr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  pixel_valid;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [COLOR_W-1:0]    pixel_color;
  logic [ADV_W-1:0]      advance;
  logic                  last;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_color, advance,
                  last, input ready);
  modport sink (input valid, pixel_valid, pixel_x, pixel_y, pixel_color, advance,
                last, output ready);
endinterface

// ===== src/bitmap_glyph_renderer.sv =====
`timescale 1ns / 1ps
// Proportional bitmap font character generator.
// in_ch carries one item per valid/ready handshake: table writes (width,
// offset, glyph byte) or a draw with character code, origin and two colors.
// out_ch carries result items: one pixel per glyph bit in raster order, with
// the glyph width as advance and last set on the final pixel; an empty glyph
// gives a single item with pixel_valid low.
// cfg_we/cfg_index/cfg_data write char_base and glyph_height; the user must write
// them only while idle, the block does not enforce it. A table write is stored at
// the handshake and leaves in_ch.ready high. A draw holds in_ch.ready low through
// the lookup, fetch and emit states; the emit state registers the first pixel and
// then one pixel per cycle while out_ch.ready is high. The rate is one glyph bit
// per cycle out of an 8-bit shift register fed by a prefetched byte from the bit
// store. A new item is taken while the last pixel still waits in the output
// register. Reset clears the sequencer and output valid and restores char_base
// to 32 and glyph_height to 8; the glyph tables keep no reset value and must be
// written before use. When out_ch.ready is low the current pixel holds and the
// walk pauses.
module bitmap_glyph_renderer import gbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gbr_in_if.sink                in_ch,
  gbr_out_if.source             out_ch
);

  logic [CODE_W-1:0] char_base_r;
  logic [HGT_W-1:0]  glyph_height_r;
  logic              accept;
  logic              idle;
  logic [CODE_W-1:0] idx_full;
  op_t               op;
  tbl_wr_t           wr;
  tbl_rd_t           rd;
  tbl_data_t         tbl;
  draw_t             draw;
  res_t              res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_base_r    <= CHAR_BASE_RST;
      glyph_height_r <= GLYPH_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHAR_BASE:    char_base_r    <= cfg_data[CODE_W-1:0];
        REG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = idle;
  assign accept      = in_ch.valid && idle;
  assign op          = op_t'(in_ch.op);
  assign idx_full    = in_ch.char_code - char_base_r;

  // Route table writes straight to the stores
  assign wr.en    = accept && op != OP_DRAW;
  assign wr.op    = op;
  assign wr.addr  = in_ch.table_addr;
  assign wr.value = in_ch.table_value;

  // Draw request
  assign draw.start  = accept && op == OP_DRAW;
  assign draw.idx    = idx_full[GIDX_W-1:0];
  assign draw.idx_ok = 32'(idx_full) < GLYPH_COUNT;
  assign draw.height = (32'(glyph_height_r) > MAX_GLYPH_HEIGHT) ? HGT_W'(MAX_GLYPH_HEIGHT)
                                                                 : glyph_height_r;
  assign draw.ox     = in_ch.origin_x;
  assign draw.oy     = in_ch.origin_y;
  assign draw.fg     = in_ch.fg_color;
  assign draw.bg     = in_ch.bg_color;

  gbr_tables u_tables (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .data (tbl)
  );

  gbr_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .draw      (draw),
    .tbl       (tbl),
    .rd        (rd),
    .idle      (idle),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .res       (res)
  );

  assign out_ch.pixel_valid = res.pixel_valid;
  assign out_ch.pixel_x     = res.pixel_x;
  assign out_ch.pixel_y     = res.pixel_y;
  assign out_ch.pixel_color = res.pixel_color;
  assign out_ch.advance     = res.advance;
  assign out_ch.last        = res.last;

endmodule

// ===== src/gbr_tables.sv =====
`timescale 1ns / 1ps
module gbr_tables import gbr_pkg::*; (
  input  logic      clk,
  input  tbl_wr_t   wr,
  input  tbl_rd_t   rd,
  output tbl_data_t data
);

  logic [ADV_W-1:0]  width_mem [GLYPH_COUNT];
  logic [OFFS_W-1:0] offset_mem [GLYPH_COUNT];
  logic [BYTE_W-1:0] glyph_mem [BIT_STORE_BYTES];

  logic [ADV_W-1:0]  width_q_r;
  logic [OFFS_W-1:0] offset_q_r;
  logic [BYTE_W-1:0] glyph_q_r;
  logic              gidx_ok;
  logic              baddr_ok;
  logic [ADV_W-1:0]  width_sat;

  assign gidx_ok  = 32'(wr.addr) < GLYPH_COUNT;
  assign baddr_ok = 32'(wr.addr) < BIT_STORE_BYTES;

  // Saturate widths on the way in
  assign width_sat = (32'(wr.value) > MAX_GLYPH_WIDTH) ? ADV_W'(MAX_GLYPH_WIDTH)
                                                       : wr.value[ADV_W-1:0];

  // Glyph index tables: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr.en && wr.op == OP_WIDTH && gidx_ok) begin
      width_mem[wr.addr[GIDX_W-1:0]] <= width_sat;
    end
    if (wr.en && wr.op == OP_OFFSET && gidx_ok) begin
      offset_mem[wr.addr[GIDX_W-1:0]] <= wr.value[OFFS_W-1:0];
    end
    if (rd.idx_re) begin
      width_q_r  <= width_mem[rd.idx];
      offset_q_r <= offset_mem[rd.idx];
    end
  end

  // Packed bit store; read data holds until the next read
  always_ff @(posedge clk) begin
    if (wr.en && wr.op == OP_BYTE && baddr_ok) begin
      glyph_mem[wr.addr[BYTE_AW-1:0]] <= wr.value[BYTE_W-1:0];
    end
    if (rd.byte_re) begin
      glyph_q_r <= glyph_mem[rd.byte_addr];
    end
  end

  assign data.width  = width_q_r;
  assign data.offset = offset_q_r;
  assign data.glyph  = glyph_q_r;

endmodule

// ===== src/gbr_walker.sv =====
`timescale 1ns / 1ps
module gbr_walker import gbr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  draw_t     draw,
  input  tbl_data_t tbl,
  output tbl_rd_t   rd,
  output logic      idle,
  input  logic      out_ready,
  output logic      out_valid,
  output res_t      res
);

  typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_FETCH, S_EMIT} state_t;

  state_t                state_r, state_nxt;
  logic [COORD_BITS-1:0] ox_r, ox_nxt;
  logic [COORD_BITS-1:0] oy_r, oy_nxt;
  logic [COLOR_W-1:0]    fg_r, fg_nxt;
  logic [COLOR_W-1:0]    bg_r, bg_nxt;
  logic                  idx_ok_r, idx_ok_nxt;
  logic [HGT_W-1:0]      h_r, h_nxt;
  logic [ADV_W-1:0]      w_r, w_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [BITC_W-1:0]     bit_r, bit_nxt;
  logic [BYTE_W-1:0]     shift_r, shift_nxt;
  logic [BYTE_AW-1:0]    baddr_r, baddr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  res_r, res_nxt;

  logic                  out_free;
  logic [ADV_W-1:0]      w_eff;
  logic                  col_end;
  logic                  row_end;

  assign out_free = !out_valid_r || out_ready;
  assign w_eff    = idx_ok_r ? tbl.width : '0;
  assign col_end  = (ADV_W'(col_r) + 1'b1) == w_r;
  assign row_end  = (HGT_W'(row_r) + 1'b1) == h_r;

  // Sequencer: look up the glyph, then shift out one bit per pixel
  always_comb begin
    state_nxt     = state_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    idx_ok_nxt    = idx_ok_r;
    h_nxt         = h_r;
    w_nxt         = w_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    bit_nxt       = bit_r;
    shift_nxt     = shift_r;
    baddr_nxt     = baddr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    rd            = '0;

    case (state_r)
      S_IDLE: begin
        if (draw.start) begin
          ox_nxt     = draw.ox;
          oy_nxt     = draw.oy;
          fg_nxt     = draw.fg;
          bg_nxt     = draw.bg;
          idx_ok_nxt = draw.idx_ok;
          h_nxt      = draw.height;
          rd.idx_re  = 1'b1;
          rd.idx     = draw.idx;
          state_nxt  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (out_free) begin
          if (w_eff == '0 || h_r == '0) begin
            // Empty glyph: report the advance only
            res_nxt.pixel_valid = 1'b0;
            res_nxt.pixel_x     = ox_r;
            res_nxt.pixel_y     = oy_r;
            res_nxt.pixel_color = '0;
            res_nxt.advance     = w_eff;
            res_nxt.last        = 1'b1;
            out_valid_nxt       = 1'b1;
            state_nxt           = S_IDLE;
          end else begin
            w_nxt        = w_eff;
            col_nxt      = '0;
            row_nxt      = '0;
            bit_nxt      = '0;
            rd.byte_re   = 1'b1;
            rd.byte_addr = tbl.offset[BYTE_AW-1:0];
            baddr_nxt    = byte_inc(tbl.offset[BYTE_AW-1:0]);
            state_nxt    = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // Load the first byte and prefetch the next
        shift_nxt    = tbl.glyph;
        rd.byte_re   = 1'b1;
        rd.byte_addr = baddr_r;
        baddr_nxt    = byte_inc(baddr_r);
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          res_nxt.pixel_valid = 1'b1;
          res_nxt.pixel_x     = ox_r + COORD_BITS'(col_r);
          res_nxt.pixel_y     = oy_r + COORD_BITS'(row_r);
          res_nxt.pixel_color = shift_r[BYTE_W-1] ? fg_r : bg_r;
          res_nxt.advance     = w_r;
          res_nxt.last        = col_end && row_end;
          out_valid_nxt       = 1'b1;
          bit_nxt             = bit_r + 1'b1;
          // Refill from the prefetched byte once this one is used up
          if (bit_r == '1) begin
            shift_nxt    = tbl.glyph;
            rd.byte_re   = 1'b1;
            rd.byte_addr = baddr_r;
            baddr_nxt    = byte_inc(baddr_r);
          end else begin
            shift_nxt = {shift_r[BYTE_W-2:0], 1'b0};
          end
          if (col_end) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
          if (col_end && row_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ox_r        <= ox_nxt;
      oy_r        <= oy_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      idx_ok_r    <= idx_ok_nxt;
      h_r         <= h_nxt;
      w_r         <= w_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      baddr_r     <= baddr_nxt;
      res_r       <= res_nxt;
    end
  end

  assign idle      = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// ===== src/gbr_checker.sv =====
`timescale 1ns / 1ps
`include "bitmap_glyph_renderer_assert.svh"
module gbr_checker import gbr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [OP_W-1:0]       in_op,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  pixel_valid,
  input logic [COORD_BITS-1:0] pixel_x,
  input logic [COORD_BITS-1:0] pixel_y,
  input logic [COLOR_W-1:0]    pixel_color,
  input logic [ADV_W-1:0]      advance,
  input logic                  last
);

  // A stalled item holds
  `GBR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color) && $stable(advance) && $stable(last), "stalled result changed")

  // An accepted draw blocks the input on the next cycle
  `GBR_ASSERT(a_draw_busy, in_valid && in_ready && in_op == OP_DRAW |=> !in_ready, "input ready after draw accept")

  // An empty-glyph report is always the final item of its draw
  `GBR_ASSERT(a_empty_last, out_valid && !pixel_valid |-> last, "empty glyph report without last")

  // Pixels carry a nonzero advance within the font limit
  `GBR_ASSERT(a_adv_range, out_valid && pixel_valid |-> advance != '0 && 32'(advance) <= MAX_GLYPH_WIDTH, "pixel advance out of range")

endmodule

bind bitmap_glyph_renderer gbr_checker u_gbr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_op       (in_ch.op),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pixel_valid (out_ch.pixel_valid),
  .pixel_x     (out_ch.pixel_x),
  .pixel_y     (out_ch.pixel_y),
  .pixel_color (out_ch.pixel_color),
  .advance     (out_ch.advance),
  .last        (out_ch.last)
);
